// ===== rtl/dclu_pkg.sv =====
package dclu_pkg;

    localparam int VALUE_W = 32;
    localparam int ID_W    = 10;
    localparam int POS_W   = 12;
    localparam int CMD_W   = 3;
    localparam int SIZE_W  = 11;
    localparam int CFG_W   = 11;

    localparam logic [ID_W-1:0] NULL_ID_RESET = 10'h3FF;
    localparam logic [ID_W-1:0] ID_ALL_ONES   = 10'h3FF;

    typedef enum logic [CMD_W-1:0] {
        CMD_DICT_WRITE = 3'd0,
        CMD_ROW_WRITE  = 3'd1,
        CMD_DECODE     = 3'd2,
        CMD_LOWER      = 3'd3,
        CMD_UPPER      = 3'd4
    } cmd_t;

    typedef enum logic {
        REG_DICT_SIZE = 1'b0,
        REG_NULL_ID   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic start;
        logic step;
        logic upper;
    } srch_ctrl_t;

    typedef struct packed {
        logic last;
    } srch_stat_t;

endpackage

// ===== rtl/dclu_ram.sv =====
module dclu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/dclu_search.sv =====
module dclu_search #(
    parameter int DICT_DEPTH = 1024
) (
    input  logic                           clk,
    input  dclu_pkg::srch_ctrl_t           ctrl,
    input  logic [$clog2(DICT_DEPTH):0]    size,
    input  logic [dclu_pkg::VALUE_W-1:0]   key,
    input  logic [dclu_pkg::VALUE_W-1:0]   probe_data,
    output logic [$clog2(DICT_DEPTH)-1:0]  probe_addr,
    output logic [$clog2(DICT_DEPTH):0]    idx,
    output dclu_pkg::srch_stat_t           stat
);

    localparam int DA = $clog2(DICT_DEPTH);
    localparam int SW = DA + 1;

    logic [SW-1:0]                lo_reg, lo_next;
    logic [SW-1:0]                n_reg, n_next;
    logic [dclu_pkg::VALUE_W-1:0] key_reg, key_next;
    logic                         upper_reg, upper_next;

    logic [SW-1:0] half;
    logic [SW-1:0] lo_step;
    logic [SW-1:0] n_step;
    logic [SW-1:0] addr_full;
    logic          go_right;

    always_comb
    begin
        half     = n_reg >> 1;
        go_right = upper_reg ? (probe_data <= key_reg) : (probe_data < key_reg);
        lo_step  = go_right ? (lo_reg + half + SW'(1)) : lo_reg;
        n_step   = go_right ? (n_reg - half - SW'(1)) : half;

        lo_next    = lo_reg;
        n_next     = n_reg;
        key_next   = key_reg;
        upper_next = upper_reg;
        if (ctrl.start)
        begin
            lo_next    = '0;
            n_next     = size;
            key_next   = key;
            upper_next = ctrl.upper;
        end
        else if (ctrl.step)
        begin
            lo_next = lo_step;
            n_next  = n_step;
        end

        // next probe goes straight to the read port
        addr_full = ctrl.start ? (size >> 1) : (lo_step + (n_step >> 1));
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        n_reg     <= n_next;
        key_reg   <= key_next;
        upper_reg <= upper_next;
    end

    assign probe_addr = addr_full[DA-1:0];
    assign idx        = lo_step;
    assign stat.last  = (n_step == '0);

endmodule

// ===== rtl/dictionary_column_lookup_unit.sv =====
// Dictionary-encoded column lookup.
// Input channel (in_valid/in_ready) takes one command word: dictionary write,
// row id write, row decode, lower-bound or upper-bound search. Output channel
// (out_valid/out_ready) returns one result word for decode and searches only.
// Config port: cfg_write with cfg_index 0 = dict_size, 1 = null_id.
// Work per command after it is accepted:
//   writes and unused commands: no result word;
//   decode: a row store read, then a dictionary read for an in-range non-null id;
//   search: one dictionary probe per binary search step until the range is empty.
// One dictionary read per cycle drives the search: each probe is one
// registered RAM read and one compare in the shared search step.
// One command in flight at a time; in_ready is high only when idle.
// A finished result sits in a holding stage while the output register is
// full; the next command is taken once it has moved to the output register.
// Reset clears control and config (dict_size 0, null_id all ones); the
// dictionary and row stores are not cleared and must be written before use.
module dictionary_column_lookup_unit #(
    parameter int DICT_DEPTH = 1024,
    parameter int ROW_DEPTH  = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dclu_pkg::CMD_W-1:0]    cmd,
    input  logic [dclu_pkg::POS_W-1:0]    position,
    input  logic [dclu_pkg::VALUE_W-1:0]  data_value,
    input  logic [dclu_pkg::ID_W-1:0]     row_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dclu_pkg::VALUE_W-1:0]  result_value,
    output logic [dclu_pkg::ID_W-1:0]     result_id,
    output logic                          is_null,
    output logic                          not_found,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [dclu_pkg::CFG_W-1:0]    cfg_data
);

    localparam int DA = $clog2(DICT_DEPTH);
    localparam int RA = $clog2(ROW_DEPTH);
    localparam int SW = DA + 1;
    localparam logic [31:0] DICT_DEPTH32 = 32'(DICT_DEPTH);
    localparam logic [31:0] ROW_DEPTH32  = 32'(ROW_DEPTH);

    typedef enum logic [2:0] {
        IDLE,
        DEC_ROW,
        DEC_DICT,
        SEARCH,
        FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [dclu_pkg::SIZE_W-1:0]  dict_size_reg, dict_size_next;
    logic [dclu_pkg::ID_W-1:0]    null_id_reg, null_id_next;

    logic [dclu_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic [dclu_pkg::ID_W-1:0]    res_id_reg, res_id_next;
    logic                         res_null_reg, res_null_next;
    logic                         res_nf_reg, res_nf_next;

    logic                         out_valid_reg, out_valid_next;
    logic [dclu_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic [dclu_pkg::ID_W-1:0]    out_id_reg, out_id_next;
    logic                         out_null_reg, out_null_next;
    logic                         out_nf_reg, out_nf_next;

    logic                         in_fire;
    logic [31:0]                  pos_ext;
    logic [31:0]                  size_ext;
    logic [SW-1:0]                size_clamped;
    logic [31:0]                  rid_ext;
    logic [31:0]                  idx_ext;

    logic                         dict_we;
    logic [DA-1:0]                dict_raddr;
    logic [dclu_pkg::VALUE_W-1:0] dict_rdata;
    logic                         row_we;
    logic [dclu_pkg::ID_W-1:0]    row_rdata;

    dclu_pkg::srch_ctrl_t         srch_ctrl;
    dclu_pkg::srch_stat_t         srch_stat;
    logic [DA-1:0]                srch_addr;
    logic [SW-1:0]                srch_idx;

    assign in_ready = (state_reg == IDLE);
    assign in_fire  = in_valid && in_ready;
    assign pos_ext  = 32'(position);
    assign size_ext = 32'(dict_size_reg);
    assign size_clamped = (size_ext > DICT_DEPTH32) ? DICT_DEPTH32[SW-1:0] : size_ext[SW-1:0];
    assign rid_ext  = 32'(row_rdata);
    assign idx_ext  = 32'(srch_idx);

    assign dict_we = in_fire && (cmd == dclu_pkg::CMD_DICT_WRITE) && (pos_ext < DICT_DEPTH32);
    assign row_we  = in_fire && (cmd == dclu_pkg::CMD_ROW_WRITE) && (pos_ext < ROW_DEPTH32);
    assign dict_raddr = (state_reg == DEC_ROW) ? rid_ext[DA-1:0] : srch_addr;

    dclu_ram #(
        .WIDTH (dclu_pkg::VALUE_W),
        .DEPTH (DICT_DEPTH)
    ) u_dict_ram (
        .clk   (clk),
        .we    (dict_we),
        .waddr (pos_ext[DA-1:0]),
        .wdata (data_value),
        .raddr (dict_raddr),
        .rdata (dict_rdata)
    );

    dclu_ram #(
        .WIDTH (dclu_pkg::ID_W),
        .DEPTH (ROW_DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (pos_ext[RA-1:0]),
        .wdata (row_id),
        .raddr (pos_ext[RA-1:0]),
        .rdata (row_rdata)
    );

    dclu_search #(
        .DICT_DEPTH (DICT_DEPTH)
    ) u_search (
        .clk        (clk),
        .ctrl       (srch_ctrl),
        .size       (size_clamped),
        .key        (data_value),
        .probe_data (dict_rdata),
        .probe_addr (srch_addr),
        .idx        (srch_idx),
        .stat       (srch_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        dict_size_next = dict_size_reg;
        null_id_next   = null_id_reg;
        res_value_next = res_value_reg;
        res_id_next    = res_id_reg;
        res_null_next  = res_null_reg;
        res_nf_next    = res_nf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_id_next    = out_id_reg;
        out_null_next  = out_null_reg;
        out_nf_next    = out_nf_reg;
        srch_ctrl      = '0;

        if (cfg_write)
        begin
            case (cfg_index)
                dclu_pkg::REG_DICT_SIZE: dict_size_next = cfg_data;
                dclu_pkg::REG_NULL_ID:   null_id_next   = cfg_data[dclu_pkg::ID_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            IDLE:
            begin
                if (in_fire)
                begin
                    case (cmd)
                        dclu_pkg::CMD_DECODE:
                        begin
                            if (pos_ext < ROW_DEPTH32)
                            begin
                                state_next = DEC_ROW;
                            end
                            else
                            begin
                                res_value_next = '0;
                                res_id_next    = null_id_reg;
                                res_null_next  = 1'b1;
                                res_nf_next    = 1'b0;
                                state_next     = FINISH;
                            end
                        end
                        dclu_pkg::CMD_LOWER, dclu_pkg::CMD_UPPER:
                        begin
                            res_value_next = '0;
                            res_null_next  = 1'b0;
                            if (size_clamped == '0)
                            begin
                                res_id_next = dclu_pkg::ID_ALL_ONES;
                                res_nf_next = 1'b1;
                                state_next  = FINISH;
                            end
                            else
                            begin
                                srch_ctrl.start = 1'b1;
                                srch_ctrl.upper = (cmd == dclu_pkg::CMD_UPPER);
                                state_next      = SEARCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            DEC_ROW:
            begin
                res_id_next = row_rdata;
                res_nf_next = 1'b0;
                if (row_rdata == null_id_reg)
                begin
                    res_value_next = '0;
                    res_null_next  = 1'b1;
                    state_next     = FINISH;
                end
                else if (rid_ext < DICT_DEPTH32)
                begin
                    res_null_next = 1'b0;
                    state_next    = DEC_DICT;
                end
                else
                begin
                    res_value_next = '0;
                    res_null_next  = 1'b0;
                    state_next     = FINISH;
                end
            end
            DEC_DICT:
            begin
                res_value_next = dict_rdata;
                state_next     = FINISH;
            end
            SEARCH:
            begin
                srch_ctrl.step = 1'b1;
                if (srch_stat.last)
                begin
                    if (srch_idx >= size_clamped)
                    begin
                        res_id_next = dclu_pkg::ID_ALL_ONES;
                        res_nf_next = 1'b1;
                    end
                    else
                    begin
                        res_id_next = idx_ext[dclu_pkg::ID_W-1:0];
                        res_nf_next = 1'b0;
                    end
                    state_next = FINISH;
                end
            end
            FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_id_next    = res_id_reg;
                    out_null_next  = res_null_reg;
                    out_nf_next    = res_nf_reg;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            dict_size_reg <= '0;
            null_id_reg   <= dclu_pkg::NULL_ID_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dict_size_reg <= dict_size_next;
            null_id_reg   <= null_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_value_reg <= res_value_next;
        res_id_reg    <= res_id_next;
        res_null_reg  <= res_null_next;
        res_nf_reg    <= res_nf_next;
        out_value_reg <= out_value_next;
        out_id_reg    <= out_id_next;
        out_null_reg  <= out_null_next;
        out_nf_reg    <= out_nf_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign result_id    = out_id_reg;
    assign is_null      = out_null_reg;
    assign not_found    = out_nf_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int DICT_DEPTH = 1024;
    localparam int ROW_DEPTH  = 4096;
    localparam int RAND_WORDS = 1550;
    localparam int LIMIT_NS   = 10_000_000;

    localparam logic [dclu_pkg::CMD_W-1:0]  CMD_SPARE_TOP = 3'd7;
    localparam logic [dclu_pkg::SIZE_W-1:0] SIZE_ALL_ONES = '1;

    typedef struct {
        logic [dclu_pkg::CMD_W-1:0]   op;
        logic [dclu_pkg::POS_W-1:0]   pos;
        logic [dclu_pkg::VALUE_W-1:0] key;
        logic [dclu_pkg::ID_W-1:0]    rid;
    } col_word_t;

    typedef struct {
        logic [dclu_pkg::VALUE_W-1:0] val;
        logic [dclu_pkg::ID_W-1:0]    vid;
        logic                         nul;
        logic                         miss;
    } lookup_res_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_ready;
    logic [dclu_pkg::CMD_W-1:0]    cmd          = '0;
    logic [dclu_pkg::POS_W-1:0]    position     = '0;
    logic [dclu_pkg::VALUE_W-1:0]  data_value   = '0;
    logic [dclu_pkg::ID_W-1:0]     row_id       = '0;
    logic                          out_valid;
    logic                          out_ready    = 1'b0;
    logic [dclu_pkg::VALUE_W-1:0]  result_value;
    logic [dclu_pkg::ID_W-1:0]     result_id;
    logic                          is_null;
    logic                          not_found;
    logic                          cfg_write    = 1'b0;
    logic                          cfg_index    = 1'b0;
    logic [dclu_pkg::CFG_W-1:0]    cfg_data     = '0;

    dictionary_column_lookup_unit #(
        .DICT_DEPTH (DICT_DEPTH),
        .ROW_DEPTH  (ROW_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .position     (position),
        .data_value   (data_value),
        .row_id       (row_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .result_id    (result_id),
        .is_null      (is_null),
        .not_found    (not_found),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state, updated as words are accepted
    logic [dclu_pkg::VALUE_W-1:0] pr_dict [DICT_DEPTH];
    logic [dclu_pkg::ID_W-1:0]    pr_rows [ROW_DEPTH];
    logic [dclu_pkg::SIZE_W-1:0]  pr_size = '0;
    logic [dclu_pkg::ID_W-1:0]    pr_null = dclu_pkg::NULL_ID_RESET;
    lookup_res_t                  due_results [$];

    // stimulus view: what will have been written once the backlog drains
    logic [dclu_pkg::VALUE_W-1:0] gv_dict [DICT_DEPTH];
    bit                           gv_dict_set [DICT_DEPTH];
    logic [dclu_pkg::ID_W-1:0]    gv_rows [ROW_DEPTH];
    bit                           gv_row_set [ROW_DEPTH];
    int                           gv_prefix = 0;
    int unsigned                  gv_size = 0;
    logic [dclu_pkg::ID_W-1:0]    gv_null = dclu_pkg::NULL_ID_RESET;
    int                           row_list [$];
    col_word_t                    cmd_backlog [$];

    col_word_t cur_word;
    int        in_gap = 0;
    int        out_stall = 0;
    int        in_gap_pct = 30;
    int        out_stall_pct = 30;
    int        n_errors = 0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_useful = 0;
    int        n_sizes = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_pct();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return 0;
        return (r == 1) ? 15 : 50;
    endfunction

    function automatic void compute_lookup(col_word_t w);
        lookup_res_t r;
        int unsigned eff, lo, n, half;
        logic        go_right;
        logic [dclu_pkg::VALUE_W-1:0] probe;
        logic [dclu_pkg::ID_W-1:0]    id;
        r = '{default: '0};
        case (w.op)
            dclu_pkg::CMD_DICT_WRITE:
            begin
                if (w.pos < DICT_DEPTH)
                    pr_dict[w.pos] = w.key;
            end
            dclu_pkg::CMD_ROW_WRITE:
            begin
                if (w.pos < ROW_DEPTH)
                    pr_rows[w.pos] = w.rid;
            end
            dclu_pkg::CMD_DECODE:
            begin
                id = (w.pos < ROW_DEPTH) ? pr_rows[w.pos] : pr_null;
                r.vid = id;
                if (id == pr_null)
                    r.nul = 1'b1;
                else if (id < DICT_DEPTH)
                    r.val = pr_dict[id];
                due_results.insert(due_results.size(), r);
            end
            dclu_pkg::CMD_LOWER, dclu_pkg::CMD_UPPER:
            begin
                eff = (pr_size > DICT_DEPTH) ? DICT_DEPTH : pr_size;
                lo = 0;
                n = eff;
                while (n > 0)
                begin
                    half = n >> 1;
                    probe = pr_dict[lo + half];
                    go_right = (w.op == dclu_pkg::CMD_UPPER) ? (probe <= w.key)
                                                             : (probe < w.key);
                    if (go_right)
                    begin
                        lo = lo + half + 1;
                        n = n - half - 1;
                    end
                    else
                        n = half;
                end
                if (lo >= eff)
                begin
                    r.vid = dclu_pkg::ID_ALL_ONES;
                    r.miss = 1'b1;
                end
                else
                    r.vid = lo[dclu_pkg::ID_W-1:0];
                due_results.insert(due_results.size(), r);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_result();
        lookup_res_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("result word with nothing outstanding, id %0h",
                                      result_id));
            return;
        end
        want = due_results.pop_front();
        n_checked++;
        if (result_value !== want.val)
            report_mismatch($sformatf("result_value %0h, want %0h", result_value, want.val));
        if (result_id !== want.vid)
            report_mismatch($sformatf("result_id %0h, want %0h", result_id, want.vid));
        if (is_null !== want.nul)
            report_mismatch($sformatf("is_null %0b, want %0b", is_null, want.nul));
        if (not_found !== want.miss)
            report_mismatch($sformatf("not_found %0b, want %0b", not_found, want.miss));
    endtask

    // command word driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                compute_lookup(cur_word);
                n_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    cur_word = cmd_backlog.pop_front();
                    in_valid   <= 1'b1;
                    cmd        <= cur_word.op;
                    position   <= cur_word.pos;
                    data_value <= cur_word.key;
                    row_id     <= cur_word.rid;
                    if ($urandom_range(0, 99) < in_gap_pct)
                        in_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result word monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < out_stall_pct)
                    out_stall = pick_gap();
            end
        end
    end

    function automatic col_word_t mk(logic [dclu_pkg::CMD_W-1:0] op, int unsigned pos,
                                     logic [dclu_pkg::VALUE_W-1:0] key, int unsigned rid);
        col_word_t w;
        w.op  = op;
        w.pos = pos[dclu_pkg::POS_W-1:0];
        w.key = key;
        w.rid = rid[dclu_pkg::ID_W-1:0];
        return w;
    endfunction

    function automatic int unsigned eff_size();
        return (gv_size > DICT_DEPTH) ? DICT_DEPTH : gv_size;
    endfunction

    function automatic bit searchable();
        return gv_prefix >= eff_size();
    endfunction

    function automatic bit decodable(int p);
        return gv_row_set[p] && (gv_rows[p] == gv_null || gv_dict_set[gv_rows[p]]);
    endfunction

    function automatic int unsigned pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return gv_null;
        if (r < 85 && gv_prefix > 0)
            return $urandom_range(0, gv_prefix - 1);
        return $urandom_range(0, (1 << dclu_pkg::ID_W) - 1);
    endfunction

    function automatic logic [dclu_pkg::VALUE_W-1:0] pick_key();
        int unsigned eff;
        int sel;
        logic [dclu_pkg::VALUE_W-1:0] base;
        eff = eff_size();
        sel = $urandom_range(0, 9);
        if (eff > 0 && sel < 6)
        begin
            base = gv_dict[$urandom_range(0, eff - 1)];
            if (sel < 2)
                return base;
            if (sel < 4)
                return base + 1;
            return base - 1;
        end
        if (sel == 6)
            return '0;
        if (sel == 7)
            return '1;
        return $urandom;
    endfunction

    task automatic send(col_word_t w);
        if (w.op == dclu_pkg::CMD_DICT_WRITE && w.pos < DICT_DEPTH)
        begin
            gv_dict[w.pos] = w.key;
            gv_dict_set[w.pos] = 1'b1;
            while (gv_prefix < DICT_DEPTH && gv_dict_set[gv_prefix])
                gv_prefix++;
        end
        if (w.op == dclu_pkg::CMD_ROW_WRITE)
        begin
            gv_rows[w.pos] = w.rid;
            gv_row_set[w.pos] = 1'b1;
            row_list.insert(row_list.size(), w.pos);
        end
        if (w.op <= dclu_pkg::CMD_UPPER
            && !(w.op == dclu_pkg::CMD_DICT_WRITE && w.pos >= DICT_DEPTH))
            n_useful++;
        cmd_backlog.insert(cmd_backlog.size(), w);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_reg(dclu_pkg::reg_index_t idx, int unsigned v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[dclu_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == dclu_pkg::REG_DICT_SIZE)
        begin
            pr_size = v[dclu_pkg::SIZE_W-1:0];
            gv_size = v[dclu_pkg::SIZE_W-1:0];
            n_sizes++;
        end
        else
        begin
            pr_null = v[dclu_pkg::ID_W-1:0];
            gv_null = v[dclu_pkg::ID_W-1:0];
        end
    endtask

    task automatic fill_sorted(int n);
        logic [dclu_pkg::VALUE_W:0] acc;
        int unsigned step_max;
        acc = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(0, 1000);
        if (n > 64)
            step_max = 4_000_000;
        else
            step_max = $urandom_range(0, 1) ? 3 : 32'hFFFF_FFFF / (n + 1);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                acc += $urandom_range(0, step_max);
            if (acc > {1'b0, {dclu_pkg::VALUE_W{1'b1}}})
                acc = {1'b0, {dclu_pkg::VALUE_W{1'b1}}};
            if (i == n - 1 && $urandom_range(0, 3) == 0)
                acc = {1'b0, {dclu_pkg::VALUE_W{1'b1}}};
            send(mk(dclu_pkg::CMD_DICT_WRITE, i, acc[dclu_pkg::VALUE_W-1:0], $urandom));
        end
    endtask

    task automatic random_ops(int count);
        int  r, p;
        bit  done;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if ((r < 38 || r >= 96) && searchable())
                send(mk($urandom_range(0, 1) ? dclu_pkg::CMD_UPPER : dclu_pkg::CMD_LOWER,
                        $urandom, pick_key(), $urandom));
            else if (r < 70 || r >= 96)
            begin
                done = 1'b0;
                for (int t = 0; t < 8 && !done && row_list.size() > 0; t++)
                begin
                    p = row_list[$urandom_range(0, row_list.size() - 1)];
                    if (decodable(p))
                    begin
                        send(mk(dclu_pkg::CMD_DECODE, p, $urandom, $urandom));
                        done = 1'b1;
                    end
                end
                if (!done)
                    send(mk(dclu_pkg::CMD_ROW_WRITE, $urandom_range(0, ROW_DEPTH - 1),
                            $urandom,
                            gv_prefix > 0 ? $urandom_range(0, gv_prefix - 1) : gv_null));
            end
            else if (r < 84)
                send(mk(dclu_pkg::CMD_ROW_WRITE, $urandom_range(0, ROW_DEPTH - 1), $urandom,
                        pick_id()));
            else if (r < 91)
            begin
                if ($urandom_range(0, 1))
                    send(mk(dclu_pkg::CMD_DICT_WRITE,
                            $urandom_range(DICT_DEPTH, (1 << dclu_pkg::POS_W) - 1),
                            $urandom, $urandom));
                else
                begin
                    p = $urandom_range(0, DICT_DEPTH - 1);
                    send(mk(dclu_pkg::CMD_DICT_WRITE, p,
                            (p < eff_size() && gv_dict_set[p]) ? gv_dict[p] : $urandom,
                            $urandom));
                end
            end
            else
                send(mk(3'($urandom_range(dclu_pkg::CMD_UPPER + 1, CMD_SPARE_TOP)),
                        $urandom, $urandom, $urandom));
        end
    endtask

    task automatic run_round(int n, int unsigned sz, int unsigned nid, int ops);
        in_gap_pct = pick_pct();
        out_stall_pct = pick_pct();
        fill_sorted(n);
        repeat (6)
            send(mk(dclu_pkg::CMD_ROW_WRITE, $urandom_range(0, ROW_DEPTH - 1), $urandom,
                    pick_id()));
        wait_idle();
        set_reg(dclu_pkg::REG_DICT_SIZE, sz);
        set_reg(dclu_pkg::REG_NULL_ID, nid);
        random_ops(ops);
    endtask

    initial
    begin
        logic [dclu_pkg::VALUE_W-1:0] seed_vals [6];
        int k, n, r, start_useful;
        seed_vals = '{32'h0, 32'h0, 32'h7, 32'd100, 32'd100, 32'hFFFF_FFFF};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty dictionary, ignored commands, write edges, decode after reset
        send(mk(dclu_pkg::CMD_LOWER, 0, '0, 0));
        send(mk(dclu_pkg::CMD_UPPER, (1 << dclu_pkg::POS_W) - 1, '1,
                (1 << dclu_pkg::ID_W) - 1));
        for (int op = dclu_pkg::CMD_UPPER + 1; op <= CMD_SPARE_TOP; op++)
            send(mk(3'(op), $urandom, $urandom, $urandom));
        send(mk(dclu_pkg::CMD_DICT_WRITE, DICT_DEPTH, $urandom, $urandom));
        send(mk(dclu_pkg::CMD_DICT_WRITE, (1 << dclu_pkg::POS_W) - 1, $urandom, $urandom));
        for (int i = 0; i < 6; i++)
            send(mk(dclu_pkg::CMD_DICT_WRITE, i, seed_vals[i], $urandom));
        send(mk(dclu_pkg::CMD_ROW_WRITE, 0, $urandom, 2));
        send(mk(dclu_pkg::CMD_ROW_WRITE, (1 << dclu_pkg::POS_W) - 1, $urandom,
                dclu_pkg::NULL_ID_RESET));
        send(mk(dclu_pkg::CMD_ROW_WRITE, 1, $urandom, 5));
        send(mk(dclu_pkg::CMD_DECODE, 0, $urandom, $urandom));
        send(mk(dclu_pkg::CMD_DECODE, (1 << dclu_pkg::POS_W) - 1, $urandom, $urandom));
        send(mk(dclu_pkg::CMD_DECODE, 1, $urandom, $urandom));
        wait_idle();
        set_reg(dclu_pkg::REG_DICT_SIZE, 6);
        set_reg(dclu_pkg::REG_NULL_ID, 5);
        send(mk(dclu_pkg::CMD_DECODE, 1, $urandom, $urandom));
        send(mk(dclu_pkg::CMD_LOWER, $urandom, 0, $urandom));
        send(mk(dclu_pkg::CMD_UPPER, $urandom, 0, $urandom));
        send(mk(dclu_pkg::CMD_LOWER, $urandom, 100, $urandom));
        send(mk(dclu_pkg::CMD_UPPER, $urandom, 100, $urandom));
        send(mk(dclu_pkg::CMD_UPPER, $urandom, '1, $urandom));
        send(mk(dclu_pkg::CMD_LOWER, $urandom, '1, $urandom));
        wait_idle();

        start_useful = n_useful;
        k = 0;
        while (n_useful - start_useful < RAND_WORDS)
        begin
            case (k)
                0: run_round(1, 1, 0, 40);
                1: run_round(0, 0, dclu_pkg::NULL_ID_RESET, 30);
                2: run_round(DICT_DEPTH, DICT_DEPTH,
                             $urandom_range(0, (1 << dclu_pkg::ID_W) - 1), 150);
                3: run_round($urandom_range(1, 30), SIZE_ALL_ONES, dclu_pkg::ID_ALL_ONES, 60);
                4: run_round($urandom_range(1, 30), $urandom_range(DICT_DEPTH + 1, 2046), 0, 50);
                default:
                begin
                    n = $urandom_range(1, 40);
                    r = $urandom_range(0, 99);
                    run_round(n,
                              (r < 70) ? n : (r < 85) ? $urandom_range(0, DICT_DEPTH) : DICT_DEPTH,
                              $urandom_range(0, (1 << dclu_pkg::ID_W) - 1),
                              $urandom_range(40, 70));
                end
            endcase
            k++;
        end

        wait_idle();
        repeat (16) @(negedge clk);
        $display("%0d command words driven, %0d result words checked over %0d rounds",
                 n_sent, n_checked, k);
        $display("%0d dictionary size settings, from empty through %0d entries to oversized",
                 n_sizes, DICT_DEPTH);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #LIMIT_NS;
        $display("Timeout with %0d result words outstanding", due_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule
